>>> rtl/mcst_pkg.sv
// Shared types and constants for the multi-channel soft timer unit.
package mcst_pkg;

  localparam int unsigned NUM_TIMERS = 4;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned NUM_W      = 3;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned MODES_W    = MODE_W * NUM_TIMERS;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_CHECK = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMERS_IN_USE = 3'd0,
    CFG_LIMIT_0       = 3'd1,
    CFG_LIMIT_1       = 3'd2,
    CFG_LIMIT_2       = 3'd3,
    CFG_LIMIT_3       = 3'd4,
    CFG_TIMER_MODES   = 3'd5
  } cfg_idx_e;

  localparam logic [MODE_W-1:0] MODE_TIMEOUT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd2;

  localparam logic [NUM_W-1:0] TIMERS_RESET = NUM_W'(NUM_TIMERS);

endpackage

>>> rtl/multi_channel_soft_timer_unit.sv
// Top level of the multi-channel soft timer unit.
// A request is held in the input register and its result in the result register;
// the result handshake is offered from the result register.
// Throughput: one request per cycle while results are taken; the input register
// and the result register each hold one request, so a stalled result backs up
// into the input stage. Reset: all timers stop with zero counts; timers_in_use
// resets to 4, limits and modes to zero.
module multi_channel_soft_timer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mcst_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // op[1:0], timer_index[3:2]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mcst_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // triggered[0], any_running[1],
                                                           // running_mask[5:2]
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mcst_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mcst_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mcst_pkg::*;

  logic [NUM_W-1:0]      timers_in_use_q;
  logic [CNT_W-1:0]      limit_q [NUM_TIMERS];
  logic [MODES_W-1:0]    timer_modes_q;

  logic                  in_valid_q;
  op_e                   op_q;
  logic [IDX_W-1:0]      idx_q;

  logic [NUM_TIMERS-1:0] running_q, running_d;
  logic [CNT_W-1:0]      count_q [NUM_TIMERS];
  logic [CNT_W-1:0]      count_d [NUM_TIMERS];

  logic                  out_valid_q;
  logic                  trig_q, trig_d;
  logic [NUM_TIMERS-1:0] mask_q;

  logic                  exec;
  logic [NUM_W-1:0]      n_eff;
  logic                  idx_ok;
  logic [MODE_W-1:0]     mode_sel;
  logic                  reached;

  assign cfg_ready_o   = 1'b1;
  assign exec          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timers_in_use_q <= TIMERS_RESET;
      timer_modes_q   <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        limit_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TIMERS_IN_USE: timers_in_use_q <= cfg_data_i[NUM_W-1:0];
        CFG_LIMIT_0:       limit_q[0]      <= cfg_data_i;
        CFG_LIMIT_1:       limit_q[1]      <= cfg_data_i;
        CFG_LIMIT_2:       limit_q[2]      <= cfg_data_i;
        CFG_LIMIT_3:       limit_q[3]      <= cfg_data_i;
        CFG_TIMER_MODES:   timer_modes_q   <= cfg_data_i[MODES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q  <= op_e'(s_axis_tdata[1:0]);
      idx_q <= s_axis_tdata[3:2];
    end
  end

  assign n_eff    = (timers_in_use_q > NUM_W'(NUM_TIMERS)) ? NUM_W'(NUM_TIMERS)
                                                           : timers_in_use_q;
  assign idx_ok   = {1'b0, idx_q} < n_eff;
  assign mode_sel = timer_modes_q[{idx_q, 1'b0} +: MODE_W];
  assign reached  = count_q[idx_q] >= limit_q[idx_q];

  always_comb begin
    running_d = running_q;
    count_d   = count_q;
    trig_d    = 1'b0;
    case (op_q)
      OP_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (running_q[i] && (NUM_W'(i) < n_eff)) begin
            count_d[i] = count_q[i] + CNT_W'(1);
          end
        end
      end
      OP_START: begin
        if (idx_ok && (mode_sel == MODE_TIMEOUT || mode_sel == MODE_PERIODIC)) begin
          count_d[idx_q]   = '0;
          running_d[idx_q] = 1'b1;
        end
      end
      OP_STOP: begin
        if (idx_ok) begin
          running_d[idx_q] = 1'b0;
        end
      end
      default: begin
        if (idx_ok && running_q[idx_q] && reached) begin
          if (mode_sel == MODE_TIMEOUT) begin
            running_d[idx_q] = 1'b0;
          end
          count_d[idx_q] = '0;
          trig_d         = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      if (exec) begin
        running_q   <= running_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      trig_q <= trig_d;
      mask_q <= running_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, mask_q, |mask_q, trig_q};

  a_any_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1] == |m_axis_tdata[5:2]))
    else $error("any_running disagrees with running_mask");

  a_trig_only_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && op_q != OP_CHECK) |=> !trig_q)
    else $error("triggered set by a request other than check");

  a_tick_keeps_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && op_q == OP_TICK) |=> running_q == $past(running_q))
    else $error("tick changed a running bit");

  a_trig_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && trig_d) |=> count_q[$past(idx_q)] == '0)
    else $error("trigger left a nonzero count");

endmodule
